[design/bgpg_pkg.sv]
// ----------------------------------------------------------------------------
// bgpg_pkg
// Shared types, constants and lookup functions of the box glyph generator.
// ----------------------------------------------------------------------------
package bgpg_pkg;

  localparam int MaxCellDimDefault = 64;

  typedef struct packed {
    logic [20:0] code_point;
    logic [5:0]  pixel_x;
    logic [5:0]  pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] coverage;
    logic       handled;
  } out_item_t;

  localparam logic [6:0] CfgCellWidth  = 7'd0;
  localparam logic [6:0] CfgCellHeight = 7'd1;

  // glyph family codes
  typedef enum logic [2:0] {
    FAM_NONE,
    FAM_CORNER,
    FAM_LINE,
    FAM_BLOCK,
    FAM_SEXTANT
  } fam_t;

  // arm bits
  localparam logic [4:0] ArmUp    = 5'd1;
  localparam logic [4:0] ArmRight = 5'd2;
  localparam logic [4:0] ArmDown  = 5'd4;
  localparam logic [4:0] ArmLeft  = 5'd8;
  localparam logic [4:0] ArmHeavy = 5'd16;

  // Arm lookup by low 7 bits of code point (0x2500..0x257B); bit 5 = found.
  function automatic logic [5:0] arm_lookup(input logic [6:0] lo);
    logic [5:0] r;
    r = 6'd0;
    case (lo)
      7'h00: r = {1'b1, ArmRight | ArmLeft};
      7'h01: r = {1'b1, ArmRight | ArmLeft | ArmHeavy};
      7'h02: r = {1'b1, ArmUp | ArmDown};
      7'h03: r = {1'b1, ArmUp | ArmDown | ArmHeavy};
      7'h0C: r = {1'b1, ArmRight | ArmDown};
      7'h10: r = {1'b1, ArmDown | ArmLeft};
      7'h14: r = {1'b1, ArmUp | ArmRight};
      7'h18: r = {1'b1, ArmUp | ArmLeft};
      7'h0F: r = {1'b1, ArmRight | ArmDown | ArmHeavy};
      7'h13: r = {1'b1, ArmDown | ArmLeft | ArmHeavy};
      7'h17: r = {1'b1, ArmUp | ArmRight | ArmHeavy};
      7'h1B: r = {1'b1, ArmUp | ArmLeft | ArmHeavy};
      7'h1C: r = {1'b1, ArmUp | ArmRight | ArmDown};
      7'h24: r = {1'b1, ArmUp | ArmDown | ArmLeft};
      7'h2C: r = {1'b1, ArmRight | ArmDown | ArmLeft};
      7'h34: r = {1'b1, ArmUp | ArmRight | ArmLeft};
      7'h23: r = {1'b1, ArmUp | ArmRight | ArmDown | ArmHeavy};
      7'h2B: r = {1'b1, ArmUp | ArmDown | ArmLeft | ArmHeavy};
      7'h33: r = {1'b1, ArmRight | ArmDown | ArmLeft | ArmHeavy};
      7'h3B: r = {1'b1, ArmUp | ArmRight | ArmLeft | ArmHeavy};
      7'h3C: r = {1'b1, ArmUp | ArmRight | ArmDown | ArmLeft};
      7'h4B: r = {1'b1, ArmUp | ArmRight | ArmDown | ArmLeft | ArmHeavy};
      7'h74: r = {1'b1, ArmLeft};
      7'h75: r = {1'b1, ArmUp};
      7'h76: r = {1'b1, ArmRight};
      7'h77: r = {1'b1, ArmDown};
      7'h78: r = {1'b1, ArmLeft | ArmHeavy};
      7'h79: r = {1'b1, ArmUp | ArmHeavy};
      7'h7A: r = {1'b1, ArmRight | ArmHeavy};
      7'h7B: r = {1'b1, ArmDown | ArmHeavy};
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] quad_lookup(input logic [3:0] i);
    logic [3:0] r;
    case (i)
      4'd0: r = 4'd4;
      4'd1: r = 4'd8;
      4'd2: r = 4'd1;
      4'd3: r = 4'd13;
      4'd4: r = 4'd9;
      4'd5: r = 4'd7;
      4'd6: r = 4'd11;
      4'd7: r = 4'd2;
      4'd8: r = 4'd6;
      4'd9: r = 4'd14;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // sextant mask: idx + idx/20 + 1, idx in 0..59
  function automatic logic [5:0] sext_mask(input logic [5:0] idx);
    logic [1:0] q;
    q = (idx >= 6'd40) ? 2'd2 : ((idx >= 6'd20) ? 2'd1 : 2'd0);
    return idx + 6'(q) + 6'd1;
  endfunction

endpackage

[design/bgpg_front.sv]
// ----------------------------------------------------------------------------
// bgpg_front
// Classifies an item and precomputes its cell geometry into a queue entry.
// ----------------------------------------------------------------------------
module bgpg_front #(
  parameter int DW = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bgpg_pkg::in_item_t  in_data,
  input  logic [DW-1:0]       w,
  input  logic [DW-1:0]       h,
  output logic                fq_valid,
  input  logic                fq_ready,
  output logic [4*DW+27:0]    fq_data
);
  // entry: fam(3) sel(7) x(6) y(6) w h  plus arms/mask(6), thickness and half thickness (DW each)
  typedef struct packed {
    bgpg_pkg::fam_t fam;
    logic [6:0]     sel;
    logic [5:0]     arm;
    logic [5:0]     px;
    logic [5:0]     py;
    logic [DW-1:0]  tl;
    logic [DW-1:0]  hd;
    logic [DW-1:0]  wd;
    logic [DW-1:0]  ht;
  } ent_t;

  ent_t ent_nxt, ent_r;
  logic v_r;
  logic [20:0] cp;
  logic [DW-1:0] m;

  assign in_ready = !v_r || fq_ready;
  assign fq_valid = v_r;
  assign cp = in_data.code_point;

  always_comb begin
    m = (w < h) ? w : h;
    ent_nxt.px = in_data.pixel_x;
    ent_nxt.py = in_data.pixel_y;
    ent_nxt.wd = w;
    ent_nxt.hd = h;
    ent_nxt.tl = ((m >> 3) == '0) ? DW'(1) : (m >> 3);
    ent_nxt.ht = '0;
    ent_nxt.sel = cp[6:0];
    ent_nxt.arm = '0;
    ent_nxt.fam = bgpg_pkg::FAM_NONE;
    if (cp >= 21'h256D && cp <= 21'h2570) begin
      ent_nxt.fam = bgpg_pkg::FAM_CORNER;
    end else if (cp >= 21'h2500 && cp <= 21'h257B) begin
      ent_nxt.arm = bgpg_pkg::arm_lookup(cp[6:0]);
      ent_nxt.fam = ent_nxt.arm[5] ? bgpg_pkg::FAM_LINE : bgpg_pkg::FAM_NONE;
    end else if (cp >= 21'h2580 && cp <= 21'h259F) begin
      ent_nxt.fam = bgpg_pkg::FAM_BLOCK;
      ent_nxt.sel = {2'b0, cp[4:0]};
      if (cp >= 21'h2596)
        ent_nxt.arm = {2'b0, bgpg_pkg::quad_lookup(4'(cp - 21'h2596))};
    end else if (cp >= 21'h1FB00 && cp <= 21'h1FB3B) begin
      ent_nxt.fam = bgpg_pkg::FAM_SEXTANT;
      ent_nxt.arm = bgpg_pkg::sext_mask(cp[5:0]);
    end
    // half thickness, light doubled for heavy lines
    if (ent_nxt.fam == bgpg_pkg::FAM_LINE && ent_nxt.arm[4])
      ent_nxt.ht = ent_nxt.tl;
    else
      ent_nxt.ht = ((ent_nxt.tl >> 1) == '0) ? DW'(1) : (ent_nxt.tl >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
    if (in_valid && in_ready) ent_r <= ent_nxt;
  end

  assign fq_data = ent_r;

endmodule

[design/bgpg_queue.sv]
// ----------------------------------------------------------------------------
// bgpg_queue
// Two-entry queue between classification and rasterization.
// ----------------------------------------------------------------------------
module bgpg_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         s_valid,
  output logic         s_ready,
  input  logic [W-1:0] s_data,
  output logic         m_valid,
  input  logic         m_ready,
  output logic [W-1:0] m_data
);
  logic [W-1:0] mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push, pop;

  assign s_ready = cnt_r != 2'd2;
  assign m_valid = cnt_r != 2'd0;
  assign m_data  = mem_r[rp_r];
  assign push = s_valid && s_ready;
  assign pop  = m_valid && m_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) mem_r[wp_r] <= s_data;
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push) else $error("queue overflow");
  a_no_under: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> !pop) else $error("queue underflow");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");

endmodule

[design/bgpg_back.sv]
// ----------------------------------------------------------------------------
// bgpg_back
// Two-stage rasterizer: products, then rectangle and circle tests.
// ----------------------------------------------------------------------------
module bgpg_back #(
  parameter int DW = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  logic [4*DW+27:0]    q_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bgpg_pkg::out_item_t out_data
);
  typedef struct packed {
    bgpg_pkg::fam_t fam;
    logic [6:0]     sel;
    logic [5:0]     arm;
    logic [5:0]     px;
    logic [5:0]     py;
    logic [DW-1:0]  tl;
    logic [DW-1:0]  hd;
    logic [DW-1:0]  wd;
    logic [DW-1:0]  ht;
  } ent_t;

  localparam int SW = DW + 3;

  ent_t e, s_r;
  logic v1_r, v2_r;
  logic s1_ready, s2_ready;
  logic signed [2*SW-1:0] d_nxt, d_r, rin2_nxt, rin2_r, rout2_nxt, rout2_r;
  logic [DW+2:0] hn_nxt, hn_r, wn_nxt, wn_r, h2_nxt, h2_r, h3_nxt, h3_r;
  bgpg_pkg::out_item_t o_nxt;

  assign e = q_data;
  assign s2_ready = !v2_r || out_ready;
  assign s1_ready = !v1_r || s2_ready;
  assign q_ready = s1_ready;
  assign out_valid = v2_r;

  // stage 1: squared distances and scaled fractions
  always_comb begin
    logic signed [SW-1:0] dx, dy, r, hh;
    logic [3:0] n;
    logic [DW+11:0] p3, p23;
    r  = SW'(((e.wd < e.hd) ? e.wd : e.hd) >> 1);
    hh = SW'(e.ht);
    dx = SW'(e.px) - SW'(e.wd >> 1);
    dy = SW'(e.py) - SW'(e.hd >> 1);
    d_nxt = dx * dx + dy * dy;
    rin2_nxt = (r - hh) * (r - hh);
    rout2_nxt = (r + hh) * (r + hh);
    n = (e.sel[4:0] <= 5'h08) ? e.sel[3:0] : 4'(5'h10 - e.sel[4:0]);
    hn_nxt = ((DW+3)'(e.hd) * (DW+3)'(n)) >> 3;
    wn_nxt = ((DW+3)'(e.wd) * (DW+3)'(n)) >> 3;
    // divide by three as multiply by 683 and shift by 11, exact below 2048
    p3  = (DW+12)'(e.hd) * (DW+12)'(683);
    p23 = (DW+12)'({e.hd, 1'b0}) * (DW+12)'(683);
    h3_nxt = (DW+3)'(p3 >> 11);
    h2_nxt = (DW+3)'(p23 >> 11);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (s1_ready) v1_r <= q_valid;
    if (q_valid && s1_ready) begin
      s_r <= e; d_r <= d_nxt; rin2_r <= rin2_nxt; rout2_r <= rout2_nxt;
      hn_r <= hn_nxt; wn_r <= wn_nxt; h2_r <= h2_nxt; h3_r <= h3_nxt;
    end
  end

  function automatic logic rect(input int x, input int y, input int x0,
                                input int y0, input int x1, input int y1);
    return x >= x0 && x < x1 && y >= y0 && y < y1;
  endfunction

  // stage 2: coverage
  always_comb begin
    int x, y, w, h, cx, cy, ht, r, y1, y3;
    logic on;
    logic [7:0] val;
    logic [4:0] s;
    x = int'(s_r.px); y = int'(s_r.py);
    w = int'(s_r.wd); h = int'(s_r.hd);
    cx = w / 2; cy = h / 2; ht = int'(s_r.ht);
    r = ((w < h) ? w : h) / 2;
    y1 = int'(h3_r); y3 = int'(h2_r);
    s = s_r.sel[4:0];
    on = 1'b0;
    val = 8'd255;
    case (s_r.fam)
      bgpg_pkg::FAM_CORNER: begin
        if (s == 5'h0D || s == 5'h10) on |= rect(x, y, cx + r, cy - ht, w, cy + ht);
        else on |= rect(x, y, 0, cy - ht, cx - r, cy + ht);
        if (s == 5'h0D || s == 5'h0E) on |= rect(x, y, cx - ht, cy + r, cx + ht, h);
        else on |= rect(x, y, cx - ht, 0, cx + ht, cy - r);
        if (!(((s == 5'h0D || s == 5'h0E) && y < cy) ||
              ((s == 5'h0F || s == 5'h10) && y > cy) ||
              ((s == 5'h0D || s == 5'h10) && x < cx) ||
              ((s == 5'h0E || s == 5'h0F) && x > cx)))
          if (d_r >= rin2_r && d_r <= rout2_r) on = 1'b1;
      end
      bgpg_pkg::FAM_LINE: begin
        if (s_r.arm[3]) on |= rect(x, y, 0, cy - ht, cx + ht, cy + ht);
        if (s_r.arm[1]) on |= rect(x, y, cx - ht, cy - ht, w, cy + ht);
        if (s_r.arm[0]) on |= rect(x, y, cx - ht, 0, cx + ht, cy + ht);
        if (s_r.arm[2]) on |= rect(x, y, cx - ht, cy - ht, cx + ht, h);
      end
      bgpg_pkg::FAM_BLOCK: begin
        if (s == 5'h00) on = rect(x, y, 0, 0, w, cy);
        else if (s <= 5'h08) on = rect(x, y, 0, h - int'(hn_r), w, h);
        else if (s <= 5'h0F) on = rect(x, y, 0, 0, int'(wn_r), h);
        else if (s == 5'h10) on = rect(x, y, cx, 0, w, h);
        else if (s <= 5'h13) begin
          on = 1'b1;
          val = (s == 5'h11) ? 8'd64 : ((s == 5'h12) ? 8'd128 : 8'd192);
        end else if (s == 5'h14) on = rect(x, y, 0, 0, w, h / 8);
        else if (s == 5'h15) on = rect(x, y, w - w / 8, 0, w, h);
        else begin
          if (s_r.arm[0]) on |= rect(x, y, 0, 0, cx, cy);
          if (s_r.arm[1]) on |= rect(x, y, cx, 0, w, cy);
          if (s_r.arm[2]) on |= rect(x, y, 0, cy, cx, h);
          if (s_r.arm[3]) on |= rect(x, y, cx, cy, w, h);
        end
      end
      bgpg_pkg::FAM_SEXTANT: begin
        if (s_r.arm[0]) on |= rect(x, y, 0, 0, cx, y1);
        if (s_r.arm[1]) on |= rect(x, y, cx, 0, w, y1);
        if (s_r.arm[2]) on |= rect(x, y, 0, y1, cx, y3);
        if (s_r.arm[3]) on |= rect(x, y, cx, y1, w, y3);
        if (s_r.arm[4]) on |= rect(x, y, 0, y3, cx, h);
        if (s_r.arm[5]) on |= rect(x, y, cx, y3, w, h);
      end
      default: on = 1'b0;
    endcase
    o_nxt.handled = s_r.fam != bgpg_pkg::FAM_NONE;
    o_nxt.coverage = (on && x < w && y < h) ? val : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (s2_ready) v2_r <= v1_r;
    if (v1_r && s2_ready) out_data <= o_nxt;
  end

  a_unh: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.handled |-> out_data.coverage == 8'd0)
    else $error("coverage on unhandled item");
  a_adv: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !out_ready |=> v2_r) else $error("result dropped");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !s2_ready |=> v1_r) else $error("stage 1 dropped");

endmodule

[design/box_glyph_pixel_generator.sv]
// ----------------------------------------------------------------------------
// box_glyph_pixel_generator
// Procedural pixel coverage for box lines, corners, blocks and sextants.
// ----------------------------------------------------------------------------
// Feed one item (code point, pixel x, pixel y) per cycle on the in_ channel;
// each yields one result (coverage, handled) on the out_ channel in order.
// Throughput is one item per cycle while out_ready is high. From accept to
// out_valid an item passes one classification register, the two-entry
// queue, then a product stage (squared radius terms, fractional cell edges)
// and a rectangle-test stage that holds the output register.
// Cell width and height come from the cfg_ channel (index 0 and 1), always
// ready; write them only while the block is idle. Values of 0 act as 1 and
// values above MAX_CELL_DIM act as MAX_CELL_DIM.
// Reset clears all valid flags and loads width 8, height 16.
// When out_ready is low, results hold, stages fill, the queue absorbs two
// items, and in_ready drops once everything is full.
// ----------------------------------------------------------------------------
module box_glyph_pixel_generator #(
  parameter int MAX_CELL_DIM = bgpg_pkg::MaxCellDimDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bgpg_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bgpg_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [6:0]          cfg_index,
  input  logic [6:0]          cfg_data
);
  localparam int DW = $clog2(MAX_CELL_DIM + 1);
  localparam int EW = DW * 4 + 28;

  logic [6:0] cw_r, ch_r;
  logic [DW-1:0] w, h;
  logic fv, fr, bv, br;
  logic [EW-1:0] fd, bd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r <= 7'd8;
      ch_r <= 7'd16;
    end else if (cfg_valid) begin
      if (cfg_index == bgpg_pkg::CfgCellWidth) cw_r <= cfg_data;
      else if (cfg_index == bgpg_pkg::CfgCellHeight) ch_r <= cfg_data;
    end
  end

  function automatic logic [DW-1:0] clampd(input logic [6:0] v);
    if (v == 7'd0) return DW'(1);
    if (32'(v) > MAX_CELL_DIM) return DW'(MAX_CELL_DIM);
    return DW'(v);
  endfunction

  assign w = clampd(cw_r);
  assign h = clampd(ch_r);

  bgpg_front #(.DW(DW)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .w, .h,
    .fq_valid(fv), .fq_ready(fr), .fq_data(fd)
  );

  bgpg_queue #(.W(EW)) u_queue (
    .clk, .rst_n, .s_valid(fv), .s_ready(fr), .s_data(fd),
    .m_valid(bv), .m_ready(br), .m_data(bd)
  );

  bgpg_back #(.DW(DW)) u_back (
    .clk, .rst_n, .q_valid(bv), .q_ready(br), .q_data(bd),
    .out_valid, .out_ready, .out_data
  );

endmodule
